>>> rtl/mdb_mfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_mfe_pkg
// Shared types and constants of the multi-drop bus master frame engine.
// ----------------------------------------------------------------------------
package mdb_mfe_pkg;

  // Register file geometry
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_RX_LIMIT  = 2'd0,
    REG_CMD_LIMIT = 2'd1,
    REG_ACK_CODE  = 2'd2,
    REG_NAK_CODE  = 2'd3
  } reg_idx_e;

  // Reset values of the registers
  localparam logic [6:0] RxLimitRst  = 7'd36;
  localparam logic [5:0] CmdLimitRst = 6'd36;
  localparam logic [7:0] AckCodeRst  = 8'h00;
  localparam logic [7:0] NakCodeRst  = 8'hAA;

  // Stream widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_CMD   = 2'd1,
    MODE_RX    = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // Receive link status
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_RECEIVING = 3'd1,
    ST_OK        = 3'd2,
    ST_BUF_ERR   = 3'd3,
    ST_CHK_ERR   = 3'd4
  } status_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [6:0] receive_limit;
    logic [5:0] command_limit;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
  } cfg_t;

  // Request to the response store
  typedef struct packed {
    logic       wr_en;
    logic [6:0] wr_idx;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [5:0] rd_idx;
  } store_req_t;

endpackage

>>> rtl/mdb_mfe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_mfe_cfg
// APB register block holding the limits and the ACK / NAK codes.
// ----------------------------------------------------------------------------
module mdb_mfe_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdb_mfe_pkg::AddrW-1:0] paddr,
  input  logic [mdb_mfe_pkg::DataW-1:0] pwdata,
  output logic [mdb_mfe_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output mdb_mfe_pkg::cfg_t           cfg_o
);
  import mdb_mfe_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e sel;
  logic     wr_en;

  assign sel    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_RX_LIMIT:  cfg_d.receive_limit = pwdata[6:0];
        REG_CMD_LIMIT: cfg_d.command_limit = pwdata[5:0];
        REG_ACK_CODE:  cfg_d.ack_code      = pwdata[7:0];
        REG_NAK_CODE:  cfg_d.nak_code      = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.receive_limit <= RxLimitRst;
      cfg_q.command_limit <= CmdLimitRst;
      cfg_q.ack_code      <= AckCodeRst;
      cfg_q.nak_code      <= NakCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    unique case (sel)
      REG_RX_LIMIT:  prdata = DataW'(cfg_q.receive_limit);
      REG_CMD_LIMIT: prdata = DataW'(cfg_q.command_limit);
      REG_ACK_CODE:  prdata = DataW'(cfg_q.ack_code);
      REG_NAK_CODE:  prdata = DataW'(cfg_q.nak_code);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/mdb_mfe_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_mfe_store
// Response byte store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mdb_mfe_store #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                    clk_i,
  input  mdb_mfe_pkg::store_req_t req_i,
  output logic [7:0]              rd_data_o
);
  import mdb_mfe_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] waddr, raddr;

  assign waddr     = AW'(req_i.wr_idx);
  assign raddr     = AW'(req_i.rd_idx);
  assign rd_data_o = rd_data_q;

  // Synchronous RAM, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[waddr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

endmodule

>>> rtl/mdb_mfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_mfe_ctrl
// Framing and receive state, store access and the result holding stage.
// ----------------------------------------------------------------------------
module mdb_mfe_ctrl #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mdb_mfe_pkg::cfg_t                    cfg_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mdb_mfe_pkg::InDataW-1:0]      s_axis_tdata,  // data_byte, read_index
  input  logic [mdb_mfe_pkg::InUserW-1:0]      s_axis_tuser,  // mode, rx_mode_bit
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mdb_mfe_pkg::OutDataW-1:0]     m_axis_tdata,  // line_byte, link_status,
                                                              // response_length,
                                                              // command_overflow
  output logic [mdb_mfe_pkg::OutUserW-1:0]     m_axis_tuser,  // line_send, line_ninth_bit
  output logic                                 m_axis_tlast,
  output mdb_mfe_pkg::store_req_t              store_req_o,
  input  logic [7:0]                           store_rd_data_i
);
  import mdb_mfe_pkg::*;

  localparam int unsigned LimCap = (STORE_DEPTH > 127) ? 127 : STORE_DEPTH;

  // Input fields
  mode_e      mode;
  logic [7:0] data_byte;
  logic       rx_mode_bit;
  logic [5:0] read_index;
  logic       accept;

  assign mode        = mode_e'(s_axis_tuser[1:0]);
  assign rx_mode_bit = s_axis_tuser[2];
  assign data_byte   = s_axis_tdata[7:0];
  assign read_index  = s_axis_tdata[13:8];

  // Scalar state
  logic [6:0] idx_q, idx_d;
  logic [7:0] rsum_q, rsum_d;
  status_e    st_q, st_d;
  logic [7:0] csum_q, csum_d;
  logic [5:0] cnt_q, cnt_d;

  // Result holding stage
  logic       p_valid_q, p_phase_q;
  logic       p_two_q, p_send_q, p_ninth_q, p_ovf_q, p_last_q, p_mem_q;
  logic [7:0] p_byte_q, p_chk_q;
  status_e    p_st_q;
  logic [5:0] p_len_q;

  // Results of the item being accepted
  logic       r_two, r_send, r_ninth, r_ovf, r_last, r_mem;
  logic [7:0] r_byte, r_chk;
  logic [5:0] r_len;
  logic       wr_en, rd_en;

  logic [6:0] lim, lm1;
  logic [7:0] csum_new;
  logic [5:0] cnt_new;
  logic       good, final_res;

  // Effective receive limit
  assign lim = (cfg_i.receive_limit > 7'(LimCap)) ? 7'(LimCap) : cfg_i.receive_limit;

  // Next state and results
  always_comb begin
    idx_d    = idx_q;
    rsum_d   = rsum_q;
    st_d     = st_q;
    csum_d   = csum_q;
    cnt_d    = cnt_q;
    r_two    = 1'b0;
    r_send   = 1'b0;
    r_ninth  = 1'b0;
    r_ovf    = 1'b0;
    r_last   = 1'b1;
    r_mem    = 1'b0;
    r_byte   = '0;
    r_chk    = '0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    good     = 1'b0;
    csum_new = csum_q + data_byte;
    cnt_new  = cnt_q + 6'd1;
    unique case (mode)
      MODE_BEGIN: begin
        idx_d  = '0;
        rsum_d = '0;
        st_d   = ST_IDLE;
        csum_d = '0;
        cnt_d  = '0;
      end
      MODE_CMD: begin
        if (cnt_q < cfg_i.command_limit) begin
          csum_d  = csum_new;
          cnt_d   = cnt_new;
          r_send  = 1'b1;
          r_byte  = data_byte;
          r_ninth = (cnt_q == '0);
          r_last  = ~s_axis_tlast;
        end else begin
          r_ovf  = 1'b1;
          r_last = ~s_axis_tlast | (cnt_q == '0);
        end
        // Closing byte: checksum follows when anything was sent
        if (s_axis_tlast) begin
          r_two  = (cnt_d != '0);
          r_chk  = csum_d;
          csum_d = '0;
          cnt_d  = '0;
        end
      end
      MODE_RX: begin
        if (!rx_mode_bit) begin
          if (idx_q < lim) begin
            wr_en  = 1'b1;
            idx_d  = idx_q + 7'd1;
            rsum_d = ((st_q == ST_IDLE) ? 8'd0 : rsum_q) + data_byte;
            st_d   = ST_RECEIVING;
          end else begin
            st_d   = ST_BUF_ERR;
            r_send = 1'b1;
            r_byte = cfg_i.nak_code;
          end
        end else if (st_q == ST_IDLE || st_q == ST_RECEIVING) begin
          r_send = 1'b1;
          if (idx_q >= lim) begin
            st_d   = ST_BUF_ERR;
            r_byte = cfg_i.nak_code;
          end else begin
            good   = (st_q == ST_IDLE) || (data_byte == rsum_q);
            wr_en  = 1'b1;
            idx_d  = idx_q + 7'd1;
            st_d   = good ? ST_OK : ST_CHK_ERR;
            r_byte = good ? cfg_i.ack_code : cfg_i.nak_code;
          end
        end
      end
      MODE_READ: begin
        rd_en = (32'(read_index) < STORE_DEPTH);
        r_mem = rd_en;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
  end

  // Response length after the update
  assign lm1   = idx_d - 7'd1;
  assign r_len = (st_d == ST_OK && idx_d != '0) ?
                 ((lm1 > 7'd63) ? 6'd63 : lm1[5:0]) : 6'd0;

  // Store access
  assign store_req_o.wr_en   = accept & wr_en;
  assign store_req_o.wr_idx  = idx_q;
  assign store_req_o.wr_data = data_byte;
  assign store_req_o.rd_en   = accept & rd_en;
  assign store_req_o.rd_idx  = read_index;

  // Handshakes
  assign final_res     = p_phase_q | ~p_two_q;
  assign s_axis_tready = ~p_valid_q | (m_axis_tready & final_res);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      rsum_q <= '0;
      st_q   <= ST_IDLE;
      csum_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      idx_q  <= idx_d;
      rsum_q <= rsum_d;
      st_q   <= st_d;
      csum_q <= csum_d;
      cnt_q  <= cnt_d;
    end
  end

  // Holding stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_phase_q <= 1'b0;
    end else if (accept) begin
      p_valid_q <= 1'b1;
      p_phase_q <= 1'b0;
    end else if (p_valid_q && m_axis_tready) begin
      if (final_res) begin
        p_valid_q <= 1'b0;
      end else begin
        p_phase_q <= 1'b1;
      end
    end
  end

  // Holding stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_two_q   <= r_two;
      p_send_q  <= r_send;
      p_ninth_q <= r_ninth;
      p_ovf_q   <= r_ovf;
      p_last_q  <= r_last;
      p_mem_q   <= r_mem;
      p_byte_q  <= r_byte;
      p_chk_q   <= r_chk;
      p_st_q    <= st_d;
      p_len_q   <= r_len;
    end
  end

  // Output selection: first result, or the checksum on the second
  logic [7:0] o_byte;
  logic       o_send, o_ninth, o_ovf, o_last;

  always_comb begin
    if (p_phase_q) begin
      o_byte  = p_chk_q;
      o_send  = 1'b1;
      o_ninth = 1'b0;
      o_ovf   = 1'b0;
      o_last  = 1'b1;
    end else begin
      o_byte  = p_mem_q ? store_rd_data_i : p_byte_q;
      o_send  = p_send_q;
      o_ninth = p_ninth_q;
      o_ovf   = p_ovf_q;
      o_last  = p_last_q;
    end
  end

  assign m_axis_tvalid = p_valid_q;
  assign m_axis_tdata  = {6'd0, o_ovf, p_len_q, p_st_q, o_byte};
  assign m_axis_tuser  = {o_ninth, o_send};
  assign m_axis_tlast  = o_last;

endmodule

>>> rtl/mdb_master_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdb_master_frame_engine
// Master framing engine for a 9-bit multi-drop vending bus: command framing
// with checksum, response capture and check, ACK / NAK and read-back.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata: data_byte[7:0], read_index[13:8];
//           |           | tuser: mode[1:0], rx_mode_bit[2]; tlast: command_last
//  m_axis   | out       | tdata: line_byte[7:0], link_status[10:8],
//           |           | response_length[16:11], command_overflow[17];
//           |           | tuser: line_send[0], line_ninth_bit[1]; tlast: last_result
//  apb      | in/out    | receive_limit, command_limit, ack_code, nak_code
//
// One item is taken per cycle while m_axis is ready; each state update is one store
// access plus an add, done at the accepting edge. A final command byte followed by
// its checksum produces two transactions and holds the input until the checksum
// leaves. A new item is taken in the cycle its predecessor's last result leaves.
// Reset clears the control state only; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module mdb_master_frame_engine #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mdb_mfe_pkg::AddrW-1:0]        paddr,
  input  logic [mdb_mfe_pkg::DataW-1:0]        pwdata,
  output logic [mdb_mfe_pkg::DataW-1:0]        prdata,
  output logic                                 pready,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mdb_mfe_pkg::InDataW-1:0]      s_axis_tdata,  // data_byte, read_index
  input  logic [mdb_mfe_pkg::InUserW-1:0]      s_axis_tuser,  // mode, rx_mode_bit
  input  logic                                 s_axis_tlast,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mdb_mfe_pkg::OutDataW-1:0]     m_axis_tdata,  // line_byte, link_status,
                                                              // response_length,
                                                              // command_overflow
  output logic [mdb_mfe_pkg::OutUserW-1:0]     m_axis_tuser,  // line_send, line_ninth_bit
  output logic                                 m_axis_tlast
);
  import mdb_mfe_pkg::*;

  cfg_t       cfg;
  store_req_t store_req;
  logic [7:0] store_rd_data;

  mdb_mfe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mdb_mfe_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (store_rd_data)
  );

  mdb_mfe_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .store_req_o     (store_req),
    .store_rd_data_i (store_rd_data)
  );

endmodule
